/* rtl/metp_pkg.sv */
// Shared types, constants and colour ramps for the escape-time pixel unit.
// No dependencies; imported by every module of the block.
package metp_pkg;

   // Fixed field widths
   localparam int C_BITS        = 32;   // Q4.28 input coordinates
   localparam int C_FRAC_BITS   = 28;
   localparam int Z_INT_BITS    = 12;   // integer bits of z
   localparam int ITER_BITS     = 10;
   localparam int RADIUS_BITS   = 8;
   localparam int COLOUR_BITS   = 8;
   localparam int MUL_DIGIT_BITS = 16;  // multiplier digit per cycle

   // Defaults for top-level parameters
   localparam int DEF_COUNT_BITS = 10;
   localparam int DEF_FRAC_BITS  = 28;

   // Register file
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam logic [ITER_BITS-1:0]   MAX_ITER_RESET = 10'd400;
   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET   = 8'd100;
   localparam logic CSR_MAX_ITER = 1'b0;
   localparam logic CSR_RADIUS   = 1'b1;

   // Colour ramp saturation points
   localparam logic [ITER_BITS-1:0] RG_SAT_COUNT   = 10'd24;
   localparam logic [ITER_BITS-1:0] BLUE_SAT_COUNT = 10'd21;
   localparam logic [COLOUR_BITS-1:0] COLOUR_FULL  = 8'd255;

   typedef struct packed {
      logic [ITER_BITS-1:0]   max_iterations;
      logic [RADIUS_BITS-1:0] escape_radius_sq;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_R,
      ST_MUL_I,
      ST_TEST,
      ST_MUL_X,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // round(255 * (n/24)^3) for n below 24
   function automatic logic [COLOUR_BITS-1:0] rg_ramp(input logic [4:0] n);
      logic [COLOUR_BITS-1:0] v;
      begin
         case (n)
            5'd4:    v = 8'd1;
            5'd5:    v = 8'd2;
            5'd6:    v = 8'd4;
            5'd7:    v = 8'd6;
            5'd8:    v = 8'd9;
            5'd9:    v = 8'd13;
            5'd10:   v = 8'd18;
            5'd11:   v = 8'd25;
            5'd12:   v = 8'd32;
            5'd13:   v = 8'd41;
            5'd14:   v = 8'd51;
            5'd15:   v = 8'd62;
            5'd16:   v = 8'd76;
            5'd17:   v = 8'd91;
            5'd18:   v = 8'd108;
            5'd19:   v = 8'd127;
            5'd20:   v = 8'd148;
            5'd21:   v = 8'd171;
            5'd22:   v = 8'd196;
            5'd23:   v = 8'd224;
            default: v = 8'd0;
         endcase
         return v;
      end
   endfunction

   // round(255 * ln(n) / 3) for n up to 20
   function automatic logic [COLOUR_BITS-1:0] blue_ramp(input logic [4:0] n);
      logic [COLOUR_BITS-1:0] v;
      begin
         case (n)
            5'd2:    v = 8'd59;
            5'd3:    v = 8'd93;
            5'd4:    v = 8'd118;
            5'd5:    v = 8'd137;
            5'd6:    v = 8'd152;
            5'd7:    v = 8'd165;
            5'd8:    v = 8'd177;
            5'd9:    v = 8'd187;
            5'd10:   v = 8'd196;
            5'd11:   v = 8'd204;
            5'd12:   v = 8'd211;
            5'd13:   v = 8'd218;
            5'd14:   v = 8'd224;
            5'd15:   v = 8'd230;
            5'd16:   v = 8'd236;
            5'd17:   v = 8'd241;
            5'd18:   v = 8'd246;
            5'd19:   v = 8'd250;
            5'd20:   v = 8'd255;
            default: v = 8'd0;
         endcase
         return v;
      end
   endfunction

endpackage

/* rtl/metp_csr.sv */
// Configuration registers (iteration limit, escape radius) behind an APB-style port.
// Depends on metp_pkg.
module metp_csr
   import metp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;
   logic    reg_sel;

   // registers sit on word boundaries; bit 2 picks the register
   assign reg_sel = paddr[2];
   assign wr_en   = psel && penable && pwrite && pready;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            CSR_MAX_ITER: cfg_in.max_iterations   = pwdata[ITER_BITS-1:0];
            CSR_RADIUS:   cfg_in.escape_radius_sq = pwdata[RADIUS_BITS-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         CSR_MAX_ITER: prdata = CSR_DATA_BITS'(cfg_ff.max_iterations);
         CSR_RADIUS:   prdata = CSR_DATA_BITS'(cfg_ff.escape_radius_sq);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_iterations   <= MAX_ITER_RESET;
         cfg_ff.escape_radius_sq <= RADIUS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/metp_mul.sv */
// Shared digit-serial unsigned multiplier: one MUL_DIGIT_BITS digit of b per cycle.
// Depends on metp_pkg.
module metp_mul
   import metp_pkg::*;
#(
   parameter int A_BITS = DEF_FRAC_BITS + 5,
   parameter int B_BITS = DEF_FRAC_BITS + 4
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [A_BITS-1:0]        a,
   input  logic [B_BITS-1:0]        b,
   output logic                     done,
   output logic [A_BITS+B_BITS-1:0] prod
);

   localparam int DW   = MUL_DIGIT_BITS;
   localparam int ND   = (B_BITS + DW - 1) / DW;
   localparam int BPW  = ND * DW;
   localparam int ACCW = A_BITS + BPW;
   localparam int CW   = (ND > 1) ? $clog2(ND) : 1;

   logic [A_BITS-1:0] a_ff, a_in;
   logic [BPW-1:0]    b_ff, b_in;
   logic [ACCW-1:0]   acc_ff, acc_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DW-1:0]     digit;
   logic [A_BITS+DW-1:0] part;

   assign digit = b_ff[BPW-1 -: DW];
   assign part  = a_ff * digit;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = BPW'(b) << (BPW - B_BITS);
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // most significant digit first: acc = acc*2^DW + a*digit
         acc_in = (acc_ff << DW) + ACCW'(part);
         b_in   = b_ff << DW;
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(ND - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   // b was padded at the low end, so the product sits at the top of acc
   assign prod = acc_ff[ACCW-1 -: (A_BITS + B_BITS)];

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("multiplier started while busy");

endmodule

/* rtl/mandelbrot_escape_time_pixel_unit.sv */
// Top level of the escape-time pixel unit: sequencer, z datapath and colour output.
// Depends on metp_pkg, metp_csr and metp_mul.
//
// One point c (signed Q4.28) in, one result out: iteration count, inside flag and
// 8-bit RGB. The unit iterates z = z*z + c from z = 0 on a single shared
// digit-serial multiplier, three products per iteration (zr^2, zi^2, 2*zr*zi).
// The first iteration needs no multiply. req_stall is high from acceptance
// until the result is in the output register; a finished result may wait on
// rsp_stall while the next point is taken. max_iterations and escape_radius_sq
// sit at byte addresses 0 and 4 and may only be written while the unit is idle.
module mandelbrot_escape_time_pixel_unit
   import metp_pkg::*;
#(
   parameter int COUNT_BITS = DEF_COUNT_BITS,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [C_BITS-1:0] req_c_real,
   input  logic signed [C_BITS-1:0] req_c_imag,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [ITER_BITS-1:0]     rsp_iter_count,
   output logic                     rsp_inside_res,
   output logic [COLOUR_BITS-1:0]   rsp_red,
   output logic [COLOUR_BITS-1:0]   rsp_green,
   output logic [COLOUR_BITS-1:0]   rsp_blue,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int ZW  = FRAC_BITS + Z_INT_BITS;  // z storage
   localparam int BW  = FRAC_BITS + 4;           // |z| below 16
   localparam int AW  = BW + 1;                  // room for 2*|zr|
   localparam int PW  = AW + BW;
   localparam int SW  = PW - FRAC_BITS;          // truncated product
   localparam int PAD = ZW - SW;
   localparam int LW  = (COUNT_BITS > ITER_BITS) ? COUNT_BITS : ITER_BITS;
   localparam int UP  = (FRAC_BITS >= C_FRAC_BITS) ? FRAC_BITS - C_FRAC_BITS : 0;
   localparam int DN  = (FRAC_BITS <  C_FRAC_BITS) ? C_FRAC_BITS - FRAC_BITS : 0;
   localparam logic [LW-1:0] COUNT_CAP = LW'((64'd1 << COUNT_BITS) - 64'd1);

   cfg_type cfg;

   state_type state_ff, state_in;

   logic signed [ZW-1:0]     cr_ff, cr_in, ci_ff, ci_in;
   logic signed [ZW-1:0]     zr_ff, zr_in, zi_ff, zi_in;
   logic [SW-1:0]            sr_ff, sr_in, si_ff, si_in, xm_ff, xm_in;
   logic [COUNT_BITS-1:0]    n_ff, n_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ITER_BITS-1:0]     rsp_count_ff, rsp_count_in;
   logic                     rsp_inside_ff, rsp_inside_in;
   logic [COLOUR_BITS-1:0]   rsp_rg_ff, rsp_rg_in, rsp_b_ff, rsp_b_in;

   logic                     accept;
   logic                     rsp_load;
   logic signed [63:0]       cr_wide, ci_wide;
   logic [ZW-1:0]            zr_abs, zi_abs;
   logic                     big;
   logic [LW-1:0]            n_ext, limit;
   logic                     n_reach;
   logic [SW:0]              sq_sum, esc_bound;
   logic                     esc;
   logic                     x_neg;
   logic signed [ZW-1:0]     xs;

   logic                     mul_start, mul_done;
   logic [AW-1:0]            mul_a;
   logic [BW-1:0]            mul_b;
   logic [PW-1:0]            mul_prod;

   metp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   metp_mul #(
      .A_BITS (AW),
      .B_BITS (BW)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign accept = req_valid && !req_stall;

   // c to Q12.FRAC_BITS; the right shift is a floor when FRAC_BITS < 28
   assign cr_wide = (64'(req_c_real) <<< UP) >>> DN;
   assign ci_wide = (64'(req_c_imag) <<< UP) >>> DN;

   assign zr_abs = zr_ff[ZW-1] ? ZW'(-zr_ff) : ZW'(zr_ff);
   assign zi_abs = zi_ff[ZW-1] ? ZW'(-zi_ff) : ZW'(zi_ff);
   assign big    = (|zr_abs[ZW-1:BW]) || (|zi_abs[ZW-1:BW]);

   assign n_ext   = LW'(n_ff);
   assign limit   = (LW'(cfg.max_iterations) > COUNT_CAP) ? COUNT_CAP
                                                          : LW'(cfg.max_iterations);
   assign n_reach = n_ext >= limit;

   assign sq_sum    = (SW+1)'(sr_ff) + (SW+1)'(si_ff);
   assign esc_bound = (SW+1)'({cfg.escape_radius_sq, {FRAC_BITS{1'b0}}});
   assign esc       = sq_sum >= esc_bound;

   assign x_neg = zr_ff[ZW-1] ^ zi_ff[ZW-1];
   assign xs    = $signed({{PAD{1'b0}}, xm_ff});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_CHECK;
         ST_CHECK:  state_in = (big || n_reach) ? ST_FINISH : ST_MUL_R;
         ST_MUL_R:  if (mul_done) state_in = ST_MUL_I;
         ST_MUL_I:  if (mul_done) state_in = ST_TEST;
         ST_TEST:   state_in = esc ? ST_FINISH : ST_MUL_X;
         ST_MUL_X:  if (mul_done) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_CHECK;
         ST_FINISH: if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: multiplier operands and handshakes
   always_comb begin
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      req_stall = 1'b1;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_CHECK: begin
            mul_start = !big && !n_reach;
            mul_a     = {1'b0, zr_abs[BW-1:0]};
            mul_b     = zr_abs[BW-1:0];
         end
         ST_MUL_R: begin
            mul_start = mul_done;
            mul_a     = {1'b0, zi_abs[BW-1:0]};
            mul_b     = zi_abs[BW-1:0];
         end
         ST_TEST: begin
            mul_start = !esc;
            mul_a     = {zr_abs[BW-1:0], 1'b0};
            mul_b     = zi_abs[BW-1:0];
         end
         ST_FINISH: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   // z datapath; with |z| below 16 before each step the new z stays well
   // inside Q12, so no saturation is ever reached
   always_comb begin
      cr_in = cr_ff;
      ci_in = ci_ff;
      zr_in = zr_ff;
      zi_in = zi_ff;
      sr_in = sr_ff;
      si_in = si_ff;
      xm_in = xm_ff;
      n_in  = n_ff;
      if (accept) begin
         // first step from z = 0 is just z = c
         cr_in = ZW'(cr_wide);
         ci_in = ZW'(ci_wide);
         zr_in = ZW'(cr_wide);
         zi_in = ZW'(ci_wide);
         n_in  = COUNT_BITS'(1);
      end
      if (mul_done && state_ff == ST_MUL_R) sr_in = mul_prod[PW-1:FRAC_BITS];
      if (mul_done && state_ff == ST_MUL_I) si_in = mul_prod[PW-1:FRAC_BITS];
      if (mul_done && state_ff == ST_MUL_X) xm_in = mul_prod[PW-1:FRAC_BITS];
      if (state_ff == ST_UPDATE) begin
         zr_in = $signed({{PAD{1'b0}}, sr_ff}) - $signed({{PAD{1'b0}}, si_ff}) + cr_ff;
         zi_in = (x_neg ? -xs : xs) + ci_ff;
         n_in  = n_ff + COUNT_BITS'(1);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_rg_in     = rsp_rg_ff;
      rsp_b_in      = rsp_b_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_count_in  = ITER_BITS'(n_ext);
         rsp_inside_in = n_reach;
         rsp_rg_in     = '0;
         rsp_b_in      = '0;
         if (!n_reach) begin
            rsp_rg_in = (n_ext >= LW'(RG_SAT_COUNT)) ? COLOUR_FULL : rg_ramp(n_ext[4:0]);
            rsp_b_in  = (n_ext >= LW'(BLUE_SAT_COUNT)) ? COLOUR_FULL
                                                       : blue_ramp(n_ext[4:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cr_ff         <= cr_in;
      ci_ff         <= ci_in;
      zr_ff         <= zr_in;
      zi_ff         <= zi_in;
      sr_ff         <= sr_in;
      si_ff         <= si_in;
      xm_ff         <= xm_in;
      n_ff          <= n_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_rg_ff     <= rsp_rg_in;
      rsp_b_ff      <= rsp_b_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_iter_count = rsp_count_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_red        = rsp_rg_ff;
   assign rsp_green      = rsp_rg_ff;
   assign rsp_blue       = rsp_b_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_CHECK && n_ff == COUNT_BITS'(1)))
      else $error("accepted item did not start at count one");

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL_R || state_ff == ST_MUL_I ||
                    state_ff == ST_MUL_X))
      else $error("multiplier finished outside a wait state");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (n_ff != '0 && n_ext <= COUNT_CAP))
      else $error("iteration count out of range");

   a_inside_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_inside_ff) |-> (rsp_rg_ff == '0 && rsp_b_ff == '0))
      else $error("inside point carries colour");

endmodule
